@@ hdl/uft_pkg.sv @@
// Package for the UDP flow table: widths, event codes, register indexes,
// controller states and the command and status structs. No dependencies.
package uft_pkg;

  localparam int unsigned DefTableDepth = 32;
  localparam int unsigned KeyW = 96;

  typedef enum logic [1:0] {
    EV_PROCESSED = 2'd0,
    EV_CREATED   = 2'd1,
    EV_EXPIRED   = 2'd2,
    EV_DROPPED   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_HALF_TIMEOUT   = 2'd0,
    REG_FULL_TIMEOUT   = 2'd1,
    REG_CHECK_INTERVAL = 2'd2,
    REG_NONE           = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP_RD,
    ST_SWEEP_EV,
    ST_FLUSH_RD,
    ST_FLUSH_EV,
    ST_LOOK,
    ST_LOOK_WAIT,
    ST_DECIDE,
    ST_REV_RD,
    ST_REV_WAIT,
    ST_EMIT_MAIN,
    ST_EMIT_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;     // take the input item
    logic       idx_clear;   // scan index back to zero
    logic       idx_step;    // scan index + 1
    logic       mark_exp;    // record whether the entry at scan index has timed out
    logic       scan_kill;   // clear valid bit at scan index
    logic       sweep_done;  // update last sweep time
    logic       look_clear;  // reset lookup hit registers
    logic       look_step;   // compare this entry with key and reverse key
    logic       do_insert;   // insert new flow / refresh existing
    logic       rd_rev;      // select the reverse entry; set its full mark on a reverse hit
    logic       out_load;    // load output register
    logic [1:0] out_sel;     // 0 scan entry, 1 created, 2 dropped, 3 processed
    logic       out_last;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic mode;
    logic is_udp;
    logic sweep_due;
    logic idx_end;        // scan index is last entry
    logic scan_valid;     // entry at scan index is to be reported
    logic any_valid_rest; // an entry to be reported exists above the scan index
    logic fwd_hit;
    logic has_free;
    logic out_busy;
  } stat_t;

endpackage

@@ hdl/uft_if.sv @@
// Valid/ready channel interfaces for the UDP flow table.
// Depends on nothing; the widths are fixed in the interfaces.
interface uft_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        is_udp;
  logic [31:0] time_sec;
  logic [31:0] src_ip;
  logic [15:0] src_port;
  logic [31:0] dst_ip;
  logic [15:0] dst_port;
  modport source (output valid, mode, is_udp, time_sec, src_ip, src_port, dst_ip, dst_port,
                  input ready);
  modport sink (input valid, mode, is_udp, time_sec, src_ip, src_port, dst_ip, dst_port,
                output ready);
endinterface

interface uft_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [31:0] flow_src_ip;
  logic [15:0] flow_src_port;
  logic [31:0] flow_dst_ip;
  logic [15:0] flow_dst_port;
  logic        flow_full;
  logic        last;
  modport source (output valid, event_res, flow_src_ip, flow_src_port, flow_dst_ip,
                  flow_dst_port, flow_full, last, input ready);
  modport sink (input valid, event_res, flow_src_ip, flow_src_port, flow_dst_ip,
                flow_dst_port, flow_full, last, output ready);
endinterface

interface uft_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/uft_datapath.sv @@
// Datapath of the UDP flow table: flow memory, valid bits, lookup registers,
// configuration registers and the output register. Uses uft_pkg.
module uft_datapath #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  uft_pkg::cmd_t  cmd,
  output uft_pkg::stat_t stat,
  uft_in_if.sink         in_ch,
  uft_out_if.source      out_ch,
  uft_cfg_if.sink        cfg_ch
);
  import uft_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  // Configuration registers.
  logic [15:0] half_to_r, full_to_r, chk_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_to_r <= 16'd60;
      full_to_r <= 16'd180;
      chk_r     <= 16'd1;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_HALF_TIMEOUT:   half_to_r <= cfg_ch.data;
        REG_FULL_TIMEOUT:   full_to_r <= cfg_ch.data;
        REG_CHECK_INTERVAL: chk_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic        mode_r, udp_r;
  logic [31:0] now_r;
  logic [KeyW-1:0] key_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_ch.mode;
      udp_r  <= in_ch.is_udp;
      now_r  <= in_ch.time_sec;
      key_r  <= {in_ch.src_ip, in_ch.src_port, in_ch.dst_ip, in_ch.dst_port};
    end
  end
  logic [KeyW-1:0] rkey;
  assign rkey = {key_r[47:16], key_r[15:0], key_r[95:64], key_r[63:48]};

  logic [31:0] last_sweep_r;
  always_ff @(posedge clk) begin
    if (!rst_n) last_sweep_r <= '0;
    else if (cmd.sweep_done) last_sweep_r <= now_r;
  end
  logic [31:0] since_sweep;
  assign since_sweep = now_r - last_sweep_r;

  // Flow memory: key, mark and seen time; valid bits in flip-flops.
  logic [KeyW-1:0] key_mem  [TABLE_DEPTH];
  logic            full_mem [TABLE_DEPTH];
  logic [31:0]     seen_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  logic [IW-1:0] idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.idx_clear) idx_r <= '0;
    else if (cmd.idx_step) idx_r <= idx_r + IW'(1);
  end

  logic [IW-1:0] fwd_idx_r, rev_idx_r, free_idx_r;
  logic          fwd_hit_r, rev_hit_r, free_hit_r;

  // Single registered read port; address chosen by command.
  logic [IW-1:0]   rd_addr;
  logic [KeyW-1:0] rd_key_r;
  logic            rd_full_r;
  logic [31:0]     rd_seen_r;
  assign rd_addr = cmd.rd_rev ? rev_idx_r : idx_r;
  always_ff @(posedge clk) begin
    rd_key_r  <= key_mem[rd_addr];
    rd_full_r <= full_mem[rd_addr];
    rd_seen_r <= seen_mem[rd_addr];
  end

  // Full mark of the processed flow (after processing).
  logic mark_r;
  logic [IW-1:0] wr_idx;
  assign wr_idx = fwd_hit_r ? fwd_idx_r : free_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      seen_mem[wr_idx] <= now_r;
      if (!fwd_hit_r) begin
        key_mem[wr_idx]  <= key_r;
        full_mem[wr_idx] <= rev_hit_r;
      end
    end else if (cmd.rd_rev && rev_hit_r) begin
      full_mem[rev_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert) mark_r <= fwd_hit_r ? full_mem[fwd_idx_r] : rev_hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (cmd.scan_kill) valid_r[idx_r] <= 1'b0;
    else if (cmd.do_insert && !fwd_hit_r) valid_r[free_idx_r] <= 1'b1;
  end

  // Lookup: one entry per cycle, pipelined behind the read register.
  logic          look_v_r;
  logic [IW-1:0] look_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.look_clear) begin
      look_v_r   <= 1'b0;
      fwd_hit_r  <= 1'b0;
      rev_hit_r  <= 1'b0;
      free_hit_r <= 1'b0;
    end else begin
      look_v_r   <= cmd.look_step;
      look_idx_r <= idx_r;
      if (look_v_r) begin
        if (valid_r[look_idx_r] && rd_key_r == key_r && !fwd_hit_r) begin
          fwd_hit_r <= 1'b1;
          fwd_idx_r <= look_idx_r;
        end
        if (valid_r[look_idx_r] && rd_key_r == rkey && !rev_hit_r) begin
          rev_hit_r <= 1'b1;
          rev_idx_r <= look_idx_r;
        end
        if (!valid_r[look_idx_r] && !free_hit_r) begin
          free_hit_r <= 1'b1;
          free_idx_r <= look_idx_r;
        end
      end
    end
  end

  logic [15:0] to_sel;
  assign to_sel = rd_full_r ? full_to_r : half_to_r;

  // The sweep first marks the timed-out flows, then reports them like a
  // flush, so that the final one is known when it is reported.
  logic                   scan_expire;
  logic [TABLE_DEPTH-1:0] exp_r, sel_mask;
  assign scan_expire = (now_r - rd_seen_r) >= {16'd0, to_sel};
  always_ff @(posedge clk) begin
    if (cmd.capture) exp_r <= '0;
    else if (cmd.mark_exp) exp_r[idx_r] <= valid_r[idx_r] && scan_expire;
  end
  assign sel_mask = mode_r ? valid_r : (valid_r & exp_r);

  logic [TABLE_DEPTH-1:0] above_mask;
  assign above_mask = ~(({{(TABLE_DEPTH-1){1'b0}}, 1'b1} << idx_r) |
                        (({{(TABLE_DEPTH-1){1'b0}}, 1'b1} << idx_r) - 1'b1));

  assign stat.mode           = mode_r;
  assign stat.is_udp         = udp_r;
  assign stat.sweep_due      = (chk_r != 16'd0) && (since_sweep >= {16'd0, chk_r});
  assign stat.idx_end        = (idx_r == IW'(TABLE_DEPTH - 1));
  assign stat.scan_valid     = sel_mask[idx_r];
  assign stat.any_valid_rest = |(sel_mask & above_mask);
  assign stat.fwd_hit        = fwd_hit_r;
  assign stat.has_free       = free_hit_r;

  // Output register.
  logic        ov_r, olast_r, ofull_r;
  logic [1:0]  oev_r;
  logic [KeyW-1:0] okey_r;
  assign stat.out_busy = ov_r && !out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      olast_r <= cmd.out_last;
      case (cmd.out_sel)
        2'd0: begin oev_r <= EV_EXPIRED;   okey_r <= rd_key_r; ofull_r <= rd_full_r; end
        2'd1: begin oev_r <= EV_CREATED;   okey_r <= key_r;    ofull_r <= mark_r;    end
        2'd2: begin oev_r <= EV_DROPPED;   okey_r <= key_r;    ofull_r <= 1'b0;      end
        default: begin
          oev_r <= EV_PROCESSED; okey_r <= key_r; ofull_r <= free_hit_r | fwd_hit_r ?
            mark_r : 1'b0;
        end
      endcase
    end
  end
  assign out_ch.valid         = ov_r;
  assign out_ch.event_res     = oev_r;
  assign out_ch.flow_src_ip   = okey_r[95:64];
  assign out_ch.flow_src_port = okey_r[63:48];
  assign out_ch.flow_dst_ip   = okey_r[47:16];
  assign out_ch.flow_dst_port = okey_r[15:0];
  assign out_ch.flow_full     = ofull_r;
  assign out_ch.last          = olast_r;
endmodule

@@ hdl/uft_ctrl.sv @@
// Controller of the UDP flow table: sequences sweep, flush, lookup, insert
// and result emission. Uses uft_pkg.
module uft_ctrl #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  uft_pkg::stat_t stat,
  output uft_pkg::cmd_t  cmd
);
  import uft_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          cmd.capture   = 1'b1;
          cmd.idx_clear = 1'b1;
          state_nxt     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.mode) state_nxt = ST_FLUSH_RD;
        else if (stat.sweep_due) begin
          cmd.sweep_done = 1'b1;
          state_nxt      = ST_SWEEP_RD;
        end else if (stat.is_udp) begin
          cmd.look_clear = 1'b1;
          state_nxt      = ST_LOOK;
        end else state_nxt = ST_IDLE;
      end
      // Sweep and flush: read the entry, then decide on it in the next cycle.
      ST_SWEEP_RD, ST_FLUSH_RD: begin
        state_nxt = (state_r == ST_SWEEP_RD) ? ST_SWEEP_EV : ST_FLUSH_EV;
      end
      // The sweep marks timed-out flows; the report pass below emits them.
      ST_SWEEP_EV: begin
        cmd.mark_exp = 1'b1;
        if (stat.idx_end) begin
          cmd.idx_clear = 1'b1;
          state_nxt     = ST_FLUSH_RD;
        end else begin
          cmd.idx_step = 1'b1;
          state_nxt    = ST_SWEEP_RD;
        end
      end
      // Report pass: every valid flow on a flush, the marked ones after a sweep.
      ST_FLUSH_EV: begin
        if (!stat.out_busy) begin
          if (stat.scan_valid) begin
            cmd.out_load  = 1'b1;
            cmd.out_sel   = 2'd0;
            cmd.scan_kill = 1'b1;
            cmd.out_last  = !stat.any_valid_rest && (stat.mode || !stat.is_udp);
          end
          if (stat.idx_end) begin
            cmd.idx_clear = 1'b1;
            if (!stat.mode && stat.is_udp) begin
              cmd.look_clear = 1'b1;
              state_nxt      = ST_LOOK;
            end else state_nxt = ST_EMIT_DONE;
          end else begin
            cmd.idx_step = 1'b1;
            state_nxt    = ST_FLUSH_RD;
          end
        end
      end
      // Lookup streams one entry per cycle through the read register.
      ST_LOOK: begin
        cmd.look_step = 1'b1;
        if (stat.idx_end) begin
          cmd.idx_clear = 1'b1;
          state_nxt     = ST_LOOK_WAIT;
        end else cmd.idx_step = 1'b1;
      end
      ST_LOOK_WAIT: state_nxt = ST_REV_RD;
      ST_REV_RD: begin
        cmd.do_insert = stat.fwd_hit || stat.has_free;
        state_nxt     = ST_REV_WAIT;
      end
      ST_REV_WAIT: begin
        cmd.rd_rev = !stat.fwd_hit && stat.has_free;
        if (!stat.out_busy) begin
          if (!stat.fwd_hit) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = stat.has_free ? 2'd1 : 2'd2;
          end
          state_nxt = ST_EMIT_MAIN;
        end
      end
      ST_EMIT_MAIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = 2'd3;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

@@ hdl/udp_flow_table_with_aging.sv @@
// Top level of the UDP flow table with idle aging.
// Depends on uft_pkg, the channel interfaces, uft_ctrl and uft_datapath.
//
//  channel | direction | carries
//  in_     | input     | packet or flush item: mode, is_udp, time, key
//  out_    | output    | events: processed, created, expired, dropped
//  cfg_    | input     | register writes: index and 16-bit data
//
// A lookup walks the table one entry a cycle. A sweep makes a marking pass and a
// report pass over the table; a flush makes a report pass. The table has a single
// memory read port. Reset (rst_n low, synchronous) empties the table and restores
// registers. A stalled output holds the controller; input is taken only when idle.
module udp_flow_table_with_aging #(
  parameter int unsigned TABLE_DEPTH = uft_pkg::DefTableDepth
) (
  input logic        clk,
  input logic        rst_n,
  uft_in_if.sink     in_ch,
  uft_out_if.source  out_ch,
  uft_cfg_if.sink    cfg_ch
);
  import uft_pkg::*;

  // Command and status join the controller and the datapath.
  cmd_t  cmd;
  stat_t stat;

  uft_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  uft_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );
endmodule

@@ bench/udp_flow_table_with_aging_tb.sv @@
// Self-checking testbench for the UDP flow table with idle aging.
// Depends on uft_pkg, the channel interfaces in uft_if.sv and the RTL top level.
module udp_flow_table_with_aging_tb;
  import uft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = DefTableDepth;
  localparam int unsigned CycleLimit = 1500000;
  // Longest stretch the receiver is held off, in cycles.
  localparam int unsigned HoldCycles = 3000;

  typedef struct packed {
    logic [1:0]  ev;
    logic [31:0] sip;
    logic [15:0] sport;
    logic [31:0] dip;
    logic [15:0] dport;
    logic        full;
    logic        last;
  } flow_event_t;

  typedef struct packed {
    logic [31:0] sip;
    logic [15:0] sport;
    logic [31:0] dip;
    logic [15:0] dport;
  } flow_key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  uft_in_if  in_ch ();
  uft_out_if out_ch ();
  uft_cfg_if cfg_ch ();

  udp_flow_table_with_aging #(.TABLE_DEPTH(Depth)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the flow table and the registers.
  logic [15:0] half_to, full_to, sweep_gap;
  logic        tbl_valid [Depth];
  flow_key_t   tbl_key [Depth];
  logic        tbl_full [Depth];
  logic [31:0] tbl_seen [Depth];
  logic [31:0] last_sweep;

  flow_event_t expected_events [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idle percentages for sender and receiver, and the long hold-off request.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  // Small pool of addresses and ports so that flows repeat and reverse flows meet.
  logic [31:0] ip_pool [4] = '{32'h0A000001, 32'hC0A80101, 32'h00000000, 32'hFFFFFFFF};
  logic [15:0] port_pool [4] = '{16'd53, 16'd0, 16'hFFFF, 16'd5000};
  logic [31:0] now_sec = 32'd0;

  task automatic report_mismatch(input string what, input flow_event_t got,
                                 input flow_event_t want);
    error_count++;
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
  endtask

  function automatic int find_flow(input flow_key_t k);
    for (int i = 0; i < Depth; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  // Queue one event; the last flag is fixed up once the item is done.
  function automatic void push_event(input event_t ev, input flow_key_t k, input logic full);
    flow_event_t e;
    e.ev = ev;
    e.sip = k.sip;
    e.sport = k.sport;
    e.dip = k.dip;
    e.dport = k.dport;
    e.full = full;
    e.last = 1'b0;
    expected_events.push_back(e);
  endfunction

  // Predicts the events one input item causes and updates the shadow table.
  function automatic void predict_flow_events(input logic mode, input logic is_udp,
                                              input logic [31:0] t, input flow_key_t k);
    int n0, fi, ri;
    logic [15:0] limit;
    logic mark;
    flow_key_t rk;
    n0 = expected_events.size();
    mark = 1'b0;
    if (mode) begin
      for (int i = 0; i < Depth; i++)
        if (tbl_valid[i]) begin
          push_event(EV_EXPIRED, tbl_key[i], tbl_full[i]);
          tbl_valid[i] = 1'b0;
        end
    end else begin
      if (sweep_gap != 0 && (t - last_sweep) >= {16'd0, sweep_gap}) begin
        for (int i = 0; i < Depth; i++)
          if (tbl_valid[i]) begin
            limit = tbl_full[i] ? full_to : half_to;
            if ((t - tbl_seen[i]) >= {16'd0, limit}) begin
              push_event(EV_EXPIRED, tbl_key[i], tbl_full[i]);
              tbl_valid[i] = 1'b0;
            end
          end
        last_sweep = t;
      end
      if (is_udp) begin
        rk = '{sip: k.dip, sport: k.dport, dip: k.sip, dport: k.sport};
        fi = find_flow(k);
        ri = find_flow(rk);
        if (fi < 0) begin
          for (int i = 0; i < Depth; i++)
            if (!tbl_valid[i] && fi < 0) fi = i;
          if (fi < 0) begin
            push_event(EV_DROPPED, k, 1'b0);
          end else begin
            tbl_valid[fi] = 1'b1;
            tbl_key[fi] = k;
            tbl_full[fi] = (ri >= 0);
            if (ri >= 0) tbl_full[ri] = 1'b1;
            tbl_seen[fi] = t;
            mark = tbl_full[fi];
            push_event(EV_CREATED, k, mark);
          end
        end else begin
          tbl_seen[fi] = t;
          mark = tbl_full[fi];
        end
        push_event(EV_PROCESSED, k, mark);
      end
    end
    if (expected_events.size() > n0)
      expected_events[expected_events.size() - 1].last = 1'b1;
  endfunction

  // Sends one item: optional idle gaps first, then holds valid until accepted.
  // Valid stays up after acceptance until the next item or the drain drops it.
  task automatic send_item(input logic mode, input logic is_udp, input logic [31:0] t,
                           input flow_key_t k);
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.is_udp <= is_udp;
    in_ch.time_sec <= t;
    in_ch.src_ip <= k.sip;
    in_ch.src_port <= k.sport;
    in_ch.dst_ip <= k.dip;
    in_ch.dst_port <= k.dport;
    do @(posedge clk); while (!in_ch.ready);
    predict_flow_events(mode, is_udp, t, k);
    @(negedge clk);
  endtask

  // Valid stays up after the write until the next item drops it.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_HALF_TIMEOUT:   half_to = value;
      REG_FULL_TIMEOUT:   full_to = value;
      REG_CHECK_INTERVAL: sweep_gap = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits until every expected event has come, then lets the block settle,
  // since a non-UDP item with a sweep that expires nothing may still be in flight.
  task automatic drain_events();
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (5 * Depth + 20) @(negedge clk);
  endtask

  function automatic flow_key_t pick_key();
    flow_key_t k;
    k.sip = ip_pool[$urandom_range(3)];
    k.sport = port_pool[$urandom_range(3)];
    k.dip = ip_pool[$urandom_range(3)];
    k.dport = port_pool[$urandom_range(3)];
    return k;
  endfunction

  function automatic flow_key_t wide_key();
    return '{sip: $urandom, sport: 16'($urandom), dip: $urandom, dport: 16'($urandom)};
  endfunction

  // Receiver: random stalls, a long hold-off on request, and the check itself.
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left <= HoldCycles;
      hold_request <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_ch.ready <= rst_n && hold_left == 0 && !hold_request &&
                    ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    flow_event_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.event_res, out_ch.flow_src_ip, out_ch.flow_src_port, out_ch.flow_dst_ip,
             out_ch.flow_dst_port, out_ch.flow_full, out_ch.last};
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected event", got, '0);
      end else begin
        want = expected_events.pop_front();
        if (got.ev !== want.ev) report_mismatch("event_res", got, want);
        if (got.sip !== want.sip || got.sport !== want.sport)
          report_mismatch("flow source", got, want);
        if (got.dip !== want.dip || got.dport !== want.dport)
          report_mismatch("flow destination", got, want);
        if (got.full !== want.full) report_mismatch("flow_full", got, want);
        if (got.last !== want.last) report_mismatch("last", got, want);
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d events outstanding", expected_events.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed: field extremes, self-reverse key, reverse flow pairing, non-UDP
  // and empty flush.
  task automatic test_directed_basics();
    flow_key_t a, b, self_rev, ext;
    a = '{sip: 32'h0A000001, sport: 16'd1234, dip: 32'hC0A80101, dport: 16'd53};
    b = '{sip: a.dip, sport: a.dport, dip: a.sip, dport: a.sport};
    self_rev = '{sip: 32'h01020304, sport: 16'd7, dip: 32'h01020304, dport: 16'd7};
    ext = '{sip: 32'hFFFFFFFF, sport: 16'hFFFF, dip: 32'h0, dport: 16'h0};
    send_item(1'b1, 1'b0, 32'd0, '0);            // flush of an empty table
    send_item(1'b0, 1'b0, 32'd0, '0);            // non-UDP, no sweep due
    send_item(1'b0, 1'b1, 32'd5, a);             // new half flow
    send_item(1'b0, 1'b1, 32'd6, a);             // refresh
    send_item(1'b0, 1'b1, 32'd7, b);             // reverse turns both full
    send_item(1'b0, 1'b1, 32'd8, self_rev);      // own reverse stays half
    send_item(1'b0, 1'b1, 32'd9, ext);
    send_item(1'b0, 1'b1, 32'd9, '0);
    send_item(1'b0, 1'b1, 32'd9, '1);
    send_item(1'b0, 1'b0, 32'd100, ext);         // non-UDP sweep expires half flows
    send_item(1'b0, 1'b1, 32'hFFFFFFFF, a);      // time wraps, everything ages out
    send_item(1'b1, 1'b1, 32'hFFFFFFFF, ext);    // flush reports the rest
    drain_events();
  endtask

  // Fills the table past its depth so that inserts are dropped.
  task automatic test_table_full();
    flow_key_t k;
    write_reg(REG_CHECK_INTERVAL, 16'd0);
    for (int i = 0; i < Depth + 3; i++) begin
      k = '{sip: 32'h0B000000 + i, sport: 16'(i), dip: 32'h0C000000, dport: 16'd80};
      send_item(1'b0, 1'b1, 32'd1000, k);
    end
    send_item(1'b0, 1'b1, 32'd1001, '{sip: 32'h0C000000, sport: 16'd80,
                                      dip: 32'h0B000001, dport: 16'd1});
    send_item(1'b1, 1'b0, 32'd0, '0);
    drain_events();
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    write_reg(REG_CHECK_INTERVAL, 16'd1);
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) begin
      now_sec += 1;
      send_item(1'b0, 1'b1, now_sec, pick_key());
    end
    drain_events();
  endtask

  // Random items under one register setting and idling mix.
  task automatic test_random_traffic(input int unsigned count, input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned roll;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      now_sec += $urandom_range(roll < 10 ? 400 : 30);
      if (roll < 4) send_item(1'b1, 1'($urandom), $urandom, wide_key());
      else if (roll < 12) send_item(1'b0, 1'b0, now_sec, wide_key());
      else if (roll < 18) send_item(1'b0, 1'b1, now_sec, wide_key());
      else send_item(1'b0, 1'b1, now_sec, pick_key());
    end
    drain_events();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_register_settings();
    write_reg(REG_HALF_TIMEOUT, 16'd20);
    write_reg(REG_FULL_TIMEOUT, 16'd60);
    write_reg(REG_CHECK_INTERVAL, 16'd5);
    test_random_traffic(30, 0, 0);
    write_reg(REG_HALF_TIMEOUT, 16'hFFFF);
    write_reg(REG_FULL_TIMEOUT, 16'hFFFF);
    write_reg(REG_CHECK_INTERVAL, 16'hFFFF);
    test_random_traffic(25, 61, 0);
    write_reg(REG_HALF_TIMEOUT, 16'd0);
    write_reg(REG_FULL_TIMEOUT, 16'd0);
    write_reg(REG_CHECK_INTERVAL, 16'd1);
    test_random_traffic(20, 0, 61);
    write_reg(REG_NONE, 16'h1234);               // unused index is ignored
    write_reg(REG_HALF_TIMEOUT, 16'd40);
    write_reg(REG_FULL_TIMEOUT, 16'd90);
    write_reg(REG_CHECK_INTERVAL, 16'd3);
    test_random_traffic(25, 14, 14);
    write_reg(REG_CHECK_INTERVAL, 16'd0);
    test_random_traffic(20, 61, 61);
  endtask

  initial begin
    half_to = 16'd60;
    full_to = 16'd180;
    sweep_gap = 16'd1;
    last_sweep = '0;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_full[i] = 1'b0;
      tbl_seen[i] = '0;
    end
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.is_udp = 1'b0;
    in_ch.time_sec = '0;
    in_ch.src_ip = '0;
    in_ch.src_port = '0;
    in_ch.dst_ip = '0;
    in_ch.dst_port = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_HALF_TIMEOUT;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_basics();
    test_table_full();
    test_output_backpressure();
    test_register_settings();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
